// ===== rtl/sgbo_pkg.sv =====
`timescale 1ns / 1ps

package sgbo_pkg;

  // operation codes
  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_INV_SPACING = 2'd0;
  localparam logic [1:0] REG_NODES_DEG   = 2'd1;
  localparam logic [1:0] REG_TOLERANCE   = 2'd2;

  // shared multiplier operand widths
  localparam int MUL_A_W = 41;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic [1:0]          op;
    logic signed [39:0]  point_x;
    logic signed [39:0]  point_y;
    logic [31:0]         relief_spacing;
    logic signed [39:0]  base_height;
    logic signed [15:0]  node_i;
    logic signed [15:0]  node_j;
    logic signed [31:0]  node_offset;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0]  height_out;
    logic signed [31:0]  read_offset;
    logic                was_changed;
    logic                table_full;
    logic [8:0]          node_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] value;
  } cfg_item_t;

endpackage

// ===== rtl/sgbo_if.sv =====
`timescale 1ns / 1ps

// input item channel
interface sgbo_in_if;
  logic              valid;
  logic              ready;
  sgbo_pkg::in_item_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// result item channel
interface sgbo_out_if;
  logic               valid;
  logic               ready;
  sgbo_pkg::out_item_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// configuration write channel
interface sgbo_cfg_if;
  logic               valid;
  logic               ready;
  sgbo_pkg::cfg_item_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/sgbo_mul.sv =====
`timescale 1ns / 1ps

// Shared signed multiplier, product registered.
module sgbo_mul (
  input  logic                                clk,
  input  logic signed [sgbo_pkg::MUL_A_W-1:0] a,
  input  logic signed [sgbo_pkg::MUL_B_W-1:0] b,
  output logic signed [sgbo_pkg::MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== rtl/sparse_grid_bilinear_offset.sv =====
`timescale 1ns / 1ps

// Sparse grid of height offsets with bilinear lookup.
// Channels: req (input items: query, set, read, clear), rsp (one result item
// per input item), cfg (register writes, always ready; index 0 inverse node
// spacing, 1 nodes per degree, 2 change tolerance).
// One item at a time: req is ready only while the sequencer is idle.
// A set or read does one key scan of the stored entries; a clear does none.
// A query does four key scans (one stored entry read per cycle) when it
// needs the table; it skips them when the weight is zero, the table is
// empty or the point lies outside the node box. The smoothstep is evaluated
// only when the weight is neither full nor zero.
// All multiplications go through one 41 x 18 multiplier with a registered
// product, stepped by the state machine.
// The result item is held in rsp until taken.
// Reset empties the table, clears the node box and loads the register
// defaults; stored entries below the fill count are the only ones ever read,
// so the table memory needs no clearing pass.
module sparse_grid_bilinear_offset #(
  parameter int NODE_CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst,
  sgbo_in_if.sink    req,
  sgbo_out_if.source rsp,
  sgbo_cfg_if.sink   cfg
);

  localparam int IW = $clog2(NODE_CAPACITY);
  localparam int CW = $clog2(NODE_CAPACITY + 1);
  localparam int AW = sgbo_pkg::MUL_A_W;
  localparam int BW = sgbo_pkg::MUL_B_W;
  localparam int PW = sgbo_pkg::MUL_P_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_W0, ST_W1, ST_W2, ST_W3, ST_T0, ST_T1, ST_T2, ST_T3, ST_CHK,
    ST_G0, ST_G1, ST_G2, ST_BOX, ST_SCAN, ST_CORNER,
    ST_I0, ST_I1, ST_I2, ST_I3, ST_I4, ST_I5, ST_I6, ST_I7, ST_I8,
    ST_F0, ST_F1, ST_SET, ST_OUT
  } state_t;

  state_t state;

  // configuration
  logic [31:0] inv_sp;
  logic [31:0] npd;
  logic [30:0] tol;

  // table
  logic [31:0]        key_mem [NODE_CAPACITY];
  logic signed [31:0] val_mem [NODE_CAPACITY];
  logic [CW-1:0]      count;
  logic signed [16:0] bmin_i, bmax_i, bmin_j, bmax_j;

  // current item and results
  sgbo_pkg::in_item_t it;
  logic signed [39:0] r_height;
  logic signed [31:0] r_read;
  logic               r_chg;
  logic               r_full;

  // scan
  logic [CW-1:0]      k;
  logic               rd_v;
  logic [31:0]        key_q;
  logic signed [31:0] val_q;
  logic [IW-1:0]      ridx;
  logic [31:0]        tkey;
  logic               fnd;
  logic signed [31:0] fval;
  logic [IW-1:0]      fidx;

  // arithmetic
  logic [63:0]        s;
  logic [15:0]        t;
  logic [15:0]        t2;
  logic [16:0]        w;
  logic               axis;
  logic [55:0]        pb;
  logic signed [26:0] ci, cj;
  logic [15:0]        tx, ty;
  logic [1:0]         corner;
  logic signed [31:0] v [4];
  logic signed [49:0] acc, south, north;
  logic signed [65:0] tot;

  logic signed [AW-1:0] ma;
  logic signed [BW-1:0] mb;
  logic signed [PW-1:0] prod;

  sgbo_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod(prod));

  // derived values
  logic signed [39:0] coord;
  logic               neg;
  logic [39:0]        mag;
  logic [16:0]        wx0, wy0;
  logic [17:0]        fac;
  logic [63:0]        sub;

  assign coord = axis ? it.point_y : it.point_x;
  assign neg   = coord[39];
  assign mag   = neg ? 40'(-coord) : 40'(coord);
  assign wx0   = 17'h10000 - {1'b0, tx};
  assign wy0   = 17'h10000 - {1'b0, ty};
  assign fac   = 18'h30000 - {1'b0, t, 1'b0};
  assign sub   = 64'h0004_0000_0000_0000 - s;

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_W0:  begin ma = {9'd0, it.relief_spacing}; mb = {2'd0, npd[15:0]}; end
      ST_W1:  begin ma = {9'd0, it.relief_spacing}; mb = {2'd0, npd[31:16]}; end
      ST_T0:  begin ma = {25'd0, t}; mb = {2'd0, t}; end
      ST_T2:  begin ma = {23'd0, fac}; mb = {2'd0, t2}; end
      ST_G0:  begin ma = {1'b0, mag}; mb = {2'd0, inv_sp[15:0]}; end
      ST_G1:  begin ma = {1'b0, mag}; mb = {2'd0, inv_sp[31:16]}; end
      ST_I0:  begin ma = {{9{v[0][31]}}, v[0]}; mb = {1'b0, wx0}; end
      ST_I1:  begin ma = {{9{v[1][31]}}, v[1]}; mb = {2'd0, tx}; end
      ST_I2:  begin ma = {{9{v[2][31]}}, v[2]}; mb = {1'b0, wx0}; end
      ST_I3:  begin ma = {{9{v[3][31]}}, v[3]}; mb = {2'd0, tx}; end
      ST_I4:  begin ma = {16'd0, south[24:0]}; mb = {1'b0, wy0}; end
      ST_I5:  begin ma = {{16{south[49]}}, south[49:25]}; mb = {1'b0, wy0}; end
      ST_I6:  begin ma = {16'd0, north[24:0]}; mb = {2'd0, ty}; end
      ST_I7:  begin ma = {{16{north[49]}}, north[49:25]}; mb = {2'd0, ty}; end
      ST_F0:  begin ma = {{8{tot[64]}}, tot[64:32]}; mb = {1'b0, w}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // grid coordinate from the two partial products
  logic [56:0]        pbr;
  logic [56:0]        qsum;
  logic [40:0]        qc;
  logic [41:0]        ux;
  logic signed [26:0] gnode;

  always_comb begin
    pbr   = neg ? (({1'b0, pb} + 57'h0FFFF) >> 16) : ({1'b0, pb} >> 16);
    qsum  = {1'b0, prod[55:0]} + pbr;
    qc    = (qsum > 57'h100_0000_0000) ? 41'h100_0000_0000 : qsum[40:0];
    ux    = neg ? (42'h100_0000_0000 - {1'b0, qc}) : (42'h100_0000_0000 + {1'b0, qc});
    gnode = $signed({1'b0, ux[41:16]}) - 27'sh100_0000;
  end

  // box test against the box widened by one node on its low side
  logic signed [27:0] ci_e, cj_e;
  logic               outside;

  always_comb begin
    ci_e    = 28'(ci);
    cj_e    = 28'(cj);
    outside = (ci_e + 28'sd1 < 28'(bmin_i)) || (ci_e > 28'(bmax_i)) ||
              (cj_e + 28'sd1 < 28'(bmin_j)) || (cj_e > 28'(bmax_j));
  end

  // key of the next corner
  logic [1:0]         ncorner;
  logic signed [26:0] ki, kj;

  always_comb begin
    ncorner = corner + 2'd1;
    ki      = ncorner[0] ? ci + 27'sd1 : ci;
    kj      = ncorner[1] ? cj + 27'sd1 : cj;
  end

  // set decision
  logic signed [32:0] sdiff;
  logic [32:0]        adiff;
  logic               do_store;
  logic               mem_we;
  logic               is_new;
  logic [IW-1:0]      waddr;

  always_comb begin
    sdiff    = 33'(it.node_offset) - 33'(fval);
    adiff    = sdiff[32] ? 33'(-sdiff) : 33'(sdiff);
    do_store = (state == ST_SET) && (adiff > {2'd0, tol});
    is_new   = !fnd;
    mem_we   = do_store && (fnd || (count < CW'(NODE_CAPACITY)));
    waddr    = fnd ? fidx : count[IW-1:0];
  end

  // final sum and saturation
  logic signed [43:0] hsum;
  logic signed [39:0] hsat;

  always_comb begin
    hsum = 44'(it.base_height) + 44'($signed(prod[58:16]));
    if (hsum > 44'sh00_7FFF_FFFF_FF)
      hsat = 40'sh7F_FFFF_FFFF;
    else if (hsum < -44'sh00_8000_0000_00)
      hsat = -40'sh80_0000_0000;
    else
      hsat = hsum[39:0];
  end

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      val_mem[waddr] <= it.node_offset;
      if (is_new) key_mem[waddr] <= {it.node_i, it.node_j};
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_mem[k[IW-1:0]];
    val_q <= val_mem[k[IW-1:0]];
    ridx  <= k[IW-1:0];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_sp <= 32'h0001_0000;
      npd    <= 32'h0001_0000;
      tol    <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        sgbo_pkg::REG_INV_SPACING: inv_sp <= cfg.data.value;
        sgbo_pkg::REG_NODES_DEG:   npd <= cfg.data.value;
        sgbo_pkg::REG_TOLERANCE:   tol <= cfg.data.value[30:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      bmin_i <= 17'sh0FFFF;
      bmin_j <= 17'sh0FFFF;
      bmax_i <= -17'sh10000;
      bmax_j <= -17'sh10000;
      k      <= '0;
      rd_v   <= 1'b0;
      axis   <= 1'b0;
      corner <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            it       <= req.data;
            r_height <= '0;
            r_read   <= '0;
            r_chg    <= 1'b0;
            r_full   <= 1'b0;
            k        <= '0;
            rd_v     <= 1'b0;
            tkey     <= {req.data.node_i, req.data.node_j};
            unique case (req.data.op)
              sgbo_pkg::OP_QUERY: state <= ST_W0;
              sgbo_pkg::OP_CLEAR: begin
                count <= '0;
                state <= ST_OUT;
              end
              default: state <= ST_SCAN;
            endcase
          end
        end
        // weight: s = relief * nodes per degree, then smoothstep
        ST_W0: state <= ST_W1;
        ST_W1: begin
          s     <= {16'd0, prod[47:0]};
          state <= ST_W2;
        end
        ST_W2: begin
          s     <= s + {prod[47:0], 16'd0};
          state <= ST_W3;
        end
        ST_W3: begin
          if (s <= 64'h0002_0000_0000_0000) begin
            w     <= 17'h10000;
            state <= ST_CHK;
          end else if (s >= 64'h0004_0000_0000_0000) begin
            w     <= '0;
            state <= ST_CHK;
          end else begin
            t     <= sub[48:33];
            state <= ST_T0;
          end
        end
        ST_T0: state <= ST_T1;
        ST_T1: begin
          t2    <= prod[31:16];
          state <= ST_T2;
        end
        ST_T2: state <= ST_T3;
        ST_T3: begin
          w     <= prod[32:16];
          state <= ST_CHK;
        end
        ST_CHK: begin
          axis <= 1'b0;
          if (w == '0 || count == '0) begin
            r_height <= it.base_height;
            state    <= ST_OUT;
          end else begin
            state <= ST_G0;
          end
        end
        // grid coordinate, x then y
        ST_G0: state <= ST_G1;
        ST_G1: begin
          pb    <= prod[55:0];
          state <= ST_G2;
        end
        ST_G2: begin
          if (!axis) begin
            ci    <= gnode;
            tx    <= ux[15:0];
            axis  <= 1'b1;
            state <= ST_G0;
          end else begin
            cj    <= gnode;
            ty    <= ux[15:0];
            state <= ST_BOX;
          end
        end
        ST_BOX: begin
          if (outside) begin
            r_height <= it.base_height;
            state    <= ST_OUT;
          end else begin
            corner <= '0;
            tkey   <= {ci[15:0], cj[15:0]};
            k      <= '0;
            rd_v   <= 1'b0;
            state  <= ST_SCAN;
          end
        end
        // key scan, one entry per cycle
        ST_SCAN: begin
          rd_v <= (k < count);
          if (k < count) k <= k + CW'(1);
          if ((rd_v && key_q == tkey) || (!rd_v && k >= count)) begin
            fnd  <= rd_v;
            fval <= rd_v ? val_q : 32'sd0;
            fidx <= ridx;
            unique case (it.op)
              sgbo_pkg::OP_QUERY: state <= ST_CORNER;
              sgbo_pkg::OP_SET:   state <= ST_SET;
              default: begin
                r_read <= rd_v ? val_q : 32'sd0;
                state  <= ST_OUT;
              end
            endcase
          end
        end
        ST_CORNER: begin
          v[corner] <= fval;
          if (corner == 2'd3) begin
            state <= ST_I0;
          end else begin
            corner <= ncorner;
            tkey   <= {ki[15:0], kj[15:0]};
            k      <= '0;
            rd_v   <= 1'b0;
            state  <= ST_SCAN;
          end
        end
        // bilinear blend
        ST_I0: state <= ST_I1;
        ST_I1: begin
          acc   <= prod[49:0];
          state <= ST_I2;
        end
        ST_I2: begin
          south <= acc + prod[49:0];
          state <= ST_I3;
        end
        ST_I3: begin
          acc   <= prod[49:0];
          state <= ST_I4;
        end
        ST_I4: begin
          north <= acc + prod[49:0];
          state <= ST_I5;
        end
        ST_I5: begin
          tot   <= 66'(prod);
          state <= ST_I6;
        end
        ST_I6: begin
          tot   <= tot + $signed({prod[40:0], 25'd0});
          state <= ST_I7;
        end
        ST_I7: begin
          tot   <= tot + 66'(prod);
          state <= ST_I8;
        end
        ST_I8: begin
          tot   <= tot + $signed({prod[40:0], 25'd0});
          state <= ST_F0;
        end
        ST_F0: state <= ST_F1;
        ST_F1: begin
          r_height <= hsat;
          state    <= ST_OUT;
        end
        // set node offset
        ST_SET: begin
          if (do_store) begin
            if (mem_we) begin
              r_chg <= 1'b1;
              if (is_new) count <= count + CW'(1);
              if (17'(it.node_i) < bmin_i) bmin_i <= 17'(it.node_i);
              if (17'(it.node_i) > bmax_i) bmax_i <= 17'(it.node_i);
              if (17'(it.node_j) < bmin_j) bmin_j <= 17'(it.node_j);
              if (17'(it.node_j) > bmax_j) bmax_j <= 17'(it.node_j);
            end else begin
              r_full <= 1'b1;
            end
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (rsp.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ports
  assign req.ready            = (state == ST_IDLE);
  assign rsp.valid            = (state == ST_OUT);
  assign rsp.data.height_out  = r_height;
  assign rsp.data.read_offset = r_read;
  assign rsp.data.was_changed = r_chg;
  assign rsp.data.table_full  = r_full;
  assign rsp.data.node_count  = 9'(count);

endmodule

// ===== tb/sparse_grid_bilinear_offset_test.sv =====
`timescale 1ns / 1ps

module sparse_grid_bilinear_offset_test;

  localparam int CAPACITY   = 256;
  localparam int STALL_PCT  = 25;
  localparam int HOLD_LEN   = 3000;
  localparam int SETTLE     = 16;
  localparam int STUCK_MAX  = 100000;
  localparam int RAND_ITEMS = 240;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sgbo_in_if  req_ch ();
  sgbo_out_if rsp_ch ();
  sgbo_cfg_if cfg_ch ();

  sparse_grid_bilinear_offset dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always #1 clk = ~clk;

  // shadow registers and node store
  logic [31:0] inv_sp;
  logic [31:0] npd;
  logic [30:0] tol;
  int          offsets [logic [31:0]];
  int          fill;
  longint      bmin_i, bmax_i, bmin_j, bmax_j;

  // expected results, written by the sender and read in order by the checker
  sgbo_pkg::out_item_t want_mem [int];
  int          sent_cnt = 0;
  int          seen_cnt = 0;
  int          errors = 0;
  bit          calm;
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_cnt;
  int          stuck_cnt = 0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // ---------------- predictor ----------------
  function automatic longint grid_coord(longint x);
    longint unsigned mag, a, b, q;
    mag = (x < 0) ? -x : x;
    a = mag * longint'(inv_sp[31:16]);
    b = mag * longint'(inv_sp[15:0]);
    q = (x < 0) ? a + ((b + 64'hFFFF) >> 16) : a + (b >> 16);
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return (x < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint node_val(longint i, longint j);
    logic [31:0] key;
    key = {i[15:0], j[15:0]};
    return offsets.exists(key) ? longint'(offsets[key]) : 0;
  endfunction

  function automatic longint fade_weight(logic [31:0] rel);
    logic [63:0] s, t, t2;
    s = {32'b0, rel} * {32'b0, npd};
    if (s <= (64'd2 << 48)) return 65536;
    if (s >= (64'd4 << 48)) return 0;
    t = ((64'd4 << 48) - s) >> 33;
    t2 = (t * t) >> 16;
    return longint'((t2 * ((64'd3 << 16) - 2 * t)) >> 16);
  endfunction

  function automatic longint grid_delta(longint x, longint y);
    longint gx, gy, i, j, tx, ty, south, north;
    logic signed [95:0] s96, n96, tot;
    gx = grid_coord(x) + (64'sd1 <<< 40);
    gy = grid_coord(y) + (64'sd1 <<< 40);
    i = (gx >>> 16) - (64'sd1 <<< 24);
    j = (gy >>> 16) - (64'sd1 <<< 24);
    tx = gx & 64'hFFFF;
    ty = gy & 64'hFFFF;
    if (i + 1 < bmin_i || i > bmax_i || j + 1 < bmin_j || j > bmax_j) return 0;
    south = node_val(i, j) * (65536 - tx) + node_val(i + 1, j) * tx;
    north = node_val(i, j + 1) * (65536 - tx) + node_val(i + 1, j + 1) * tx;
    s96 = south;
    n96 = north;
    tot = s96 * (65536 - ty) + n96 * ty;
    return longint'(tot >>> 32);
  endfunction

  function automatic sgbo_pkg::out_item_t grid_result(sgbo_pkg::in_item_t it);
    sgbo_pkg::out_item_t r;
    logic [31:0]         key;
    longint              h, w, dz, old, diff, tl, ni, nj;
    r = '0;
    key = {it.node_i, it.node_j};
    ni = longint'(it.node_i);
    nj = longint'(it.node_j);
    case (it.op)
      sgbo_pkg::OP_QUERY: begin
        h = longint'(it.base_height);
        w = fade_weight(it.relief_spacing);
        if (w > 0 && fill > 0) begin
          h = h + ((w * grid_delta(it.point_x, it.point_y)) >>> 16);
          if (h > (64'sd1 <<< 39) - 1) h = (64'sd1 <<< 39) - 1;
          if (h < -(64'sd1 <<< 39)) h = -(64'sd1 <<< 39);
        end
        r.height_out = h[39:0];
      end
      sgbo_pkg::OP_SET: begin
        dz = longint'(it.node_offset);
        old = offsets.exists(key) ? longint'(offsets[key]) : 0;
        diff = dz - old;
        if (diff < 0) diff = -diff;
        tl = tol;
        if (diff > tl) begin
          if (!offsets.exists(key) && fill >= CAPACITY) begin
            r.table_full = 1'b1;
          end else begin
            if (!offsets.exists(key)) fill++;
            offsets[key] = it.node_offset;
            r.was_changed = 1'b1;
            if (ni < bmin_i) bmin_i = ni;
            if (ni > bmax_i) bmax_i = ni;
            if (nj < bmin_j) bmin_j = nj;
            if (nj > bmax_j) bmax_j = nj;
          end
        end
      end
      sgbo_pkg::OP_READ: r.read_offset = offsets.exists(key) ? offsets[key] : 0;
      default: begin
        offsets.delete();
        fill = 0;
      end
    endcase
    r.node_count = fill[8:0];
    return r;
  endfunction

  // ---------------- channel drivers ----------------
  task automatic send_item(sgbo_pkg::in_item_t it);
    if (!calm) begin
      while ($urandom_range(99) < STALL_PCT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    do @(posedge clk); while (!req_ch.ready);
    want_mem[sent_cnt] = grid_result(it);
    sent_cnt++;
  endtask

  // let every result come back, then give the block time to go idle
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (seen_cnt != sent_cnt) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      sgbo_pkg::REG_INV_SPACING: inv_sp = val;
      sgbo_pkg::REG_NODES_DEG:   npd = val;
      default:                   tol = val[30:0];
    endcase
  endtask

  task automatic set_regs(logic [31:0] inv, logic [31:0] nd, logic [31:0] tl);
    drain();
    write_reg(sgbo_pkg::REG_INV_SPACING, inv);
    write_reg(sgbo_pkg::REG_NODES_DEG, nd);
    write_reg(sgbo_pkg::REG_TOLERANCE, tl);
  endtask

  // ---------------- item builders ----------------
  function automatic sgbo_pkg::in_item_t noise_item(logic [1:0] op);
    sgbo_pkg::in_item_t it;
    it.op             = op;
    it.point_x        = 40'({$urandom, $urandom});
    it.point_y        = 40'({$urandom, $urandom});
    it.relief_spacing = $urandom;
    it.base_height    = 40'({$urandom, $urandom});
    it.node_i         = 16'($urandom);
    it.node_j         = 16'($urandom);
    it.node_offset    = $urandom;
    return it;
  endfunction

  function automatic sgbo_pkg::in_item_t node_item(logic [1:0] op, int i, int j, int val);
    sgbo_pkg::in_item_t it;
    it = noise_item(op);
    it.node_i = 16'(i);
    it.node_j = 16'(j);
    it.node_offset = val;
    return it;
  endfunction

  // point whose grid coordinate lands near g (Q16.16 grid units)
  function automatic logic [39:0] point_at(longint g);
    longint p;
    if (inv_sp == 0) return 40'({$urandom, $urandom});
    p = (g <<< 16) / longint'(inv_sp);
    if (p > (64'sd1 <<< 39) - 1) p = (64'sd1 <<< 39) - 1;
    if (p < -(64'sd1 <<< 39)) p = -(64'sd1 <<< 39);
    return p[39:0];
  endfunction

  function automatic sgbo_pkg::in_item_t query_item(longint gx, longint gy,
                                                    logic [31:0] rel, longint base);
    sgbo_pkg::in_item_t it;
    it = noise_item(sgbo_pkg::OP_QUERY);
    it.point_x = point_at(gx);
    it.point_y = point_at(gy);
    it.relief_spacing = rel;
    it.base_height = 40'(base);
    return it;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    longint hmax;
    hmax = (64'sd1 <<< 39) - 1;
    send_item(query_item(0, 0, 0, 12345));                   // empty store
    send_item(node_item(sgbo_pkg::OP_SET, 0, 0, 32'h0001_0000));
    send_item(node_item(sgbo_pkg::OP_SET, 1, 0, -32'sh0003_0000));
    send_item(node_item(sgbo_pkg::OP_SET, 1, 1, 32'h0002_8000));
    send_item(node_item(sgbo_pkg::OP_SET, 1, 1, 32'h0002_8000)); // unchanged value
    send_item(node_item(sgbo_pkg::OP_SET, 0, 1, 0));         // zero, not stored
    send_item(query_item(32'h8000, 32'h4000, 0, 0));         // between nodes
    send_item(query_item(32'h1_0000, 32'h1_0000, 0, -77));   // on a node
    send_item(query_item(64'sh40_0000, 0, 0, 5));            // outside the box
    drain();
    write_reg(sgbo_pkg::REG_NODES_DEG, 32'h0004_0000);
    send_item(query_item(32'h8000, 32'h8000, 32'hFFFF_FFFF, 9)); // weight zero
    send_item(query_item(32'h8000, 32'h8000, 32'h0000_C000, 9)); // full weight
    send_item(query_item(32'h8000, 32'h8000, 32'hC000_0000, 9)); // fade region
    send_item(query_item(32'h8000, 32'h8000, 32'h8000_0001, 9));
    send_item(node_item(sgbo_pkg::OP_SET, 0, 0, 32'h7FFF_FFFF));
    send_item(query_item(0, 0, 0, hmax));                    // saturate high
    send_item(node_item(sgbo_pkg::OP_SET, 0, 0, 32'h8000_0000));
    send_item(query_item(0, 0, 0, -hmax - 1));               // saturate low
    send_item(node_item(sgbo_pkg::OP_SET, -32768, -32768, 32'h8000_0000));
    send_item(node_item(sgbo_pkg::OP_SET, 32767, 32767, 32'h7FFF_FFFF));
    send_item(node_item(sgbo_pkg::OP_READ, -32768, -32768, 0));
    send_item(node_item(sgbo_pkg::OP_READ, 32767, 32767, 0));
    send_item(node_item(sgbo_pkg::OP_READ, 5, 5, 0));        // absent node
    send_item(noise_item(sgbo_pkg::OP_CLEAR));
    send_item(node_item(sgbo_pkg::OP_READ, 0, 0, 0));
    send_item(query_item(0, 0, 0, 3));                       // empty after clear
    drain();
  endtask

  task automatic test_table_full();
    for (int k = 0; k < CAPACITY; k++)
      send_item(node_item(sgbo_pkg::OP_SET, k - 128, 7, k + 1));
    send_item(node_item(sgbo_pkg::OP_SET, 200, 200, 99));    // no free entry
    send_item(node_item(sgbo_pkg::OP_SET, 0, 7, -5));        // existing still writes
    send_item(query_item(32'h8000, 32'h7_8000, 0, 0));
    send_item(noise_item(sgbo_pkg::OP_CLEAR));
    send_item(node_item(sgbo_pkg::OP_SET, 200, 200, 99));
    drain();
  endtask

  task automatic test_back_pressure();
    send_item(noise_item(sgbo_pkg::OP_CLEAR));
    hold_asks++;
    for (int k = 0; k < 8; k++)
      send_item(node_item(sgbo_pkg::OP_SET, k % 3, k / 3, $urandom));
    send_item(query_item(32'h8000, 32'h8000, 0, 0));
    drain();                                                 // sender pauses here
  endtask

  task automatic test_random_traffic();
    sgbo_pkg::in_item_t it;
    int                 r;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 60 == 0) begin
        case (n / 60)
          0: set_regs(32'h0001_0000, 32'h0001_0000, 0);
          1: set_regs(32'h0000_8000, 32'h0003_0000, 32'h0001_0000);
          2: set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
          default: set_regs(32'h0000_0001, 32'h0000_0001, 32'h0000_0100);
        endcase
        send_item(noise_item(sgbo_pkg::OP_CLEAR));
      end
      calm = (n >= 40 && n < 100);
      r = $urandom_range(99);
      if (r < 30)
        it = node_item(sgbo_pkg::OP_SET, $urandom_range(8) - 4, $urandom_range(8) - 4,
                       ($urandom_range(1) != 0) ? $urandom : $urandom_range(65536 * 4));
      else if (r < 34)
        it = noise_item(sgbo_pkg::OP_SET);
      else if (r < 48)
        it = node_item(sgbo_pkg::OP_READ, $urandom_range(8) - 4, $urandom_range(8) - 4, 0);
      else if (r < 85)
        it = query_item(longint'($urandom_range(655360)) - 327680,
                        longint'($urandom_range(655360)) - 327680,
                        $urandom, {$urandom, $urandom});
      else if (r < 96)
        it = noise_item(sgbo_pkg::OP_QUERY);
      else
        it = noise_item(sgbo_pkg::OP_CLEAR);
      send_item(it);
    end
    calm = 1'b0;
    drain();
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    sgbo_pkg::out_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (seen_cnt == sent_cnt) begin
        report("unexpected result", longint'(rsp_ch.data.height_out), 0);
      end else begin
        want = want_mem[seen_cnt];
        seen_cnt++;
        if (rsp_ch.data.height_out !== want.height_out)
          report("height_out", longint'(rsp_ch.data.height_out),
                 longint'(want.height_out));
        if (rsp_ch.data.read_offset !== want.read_offset)
          report("read_offset", longint'(rsp_ch.data.read_offset),
                 longint'(want.read_offset));
        if (rsp_ch.data.was_changed !== want.was_changed)
          report("was_changed", longint'(rsp_ch.data.was_changed),
                 longint'(want.was_changed));
        if (rsp_ch.data.table_full !== want.table_full)
          report("table_full", longint'(rsp_ch.data.table_full),
                 longint'(want.table_full));
        if (rsp_ch.data.node_count !== want.node_count)
          report("node_count", longint'(rsp_ch.data.node_count),
                 longint'(want.node_count));
      end
    end
  end

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_seen != hold_asks) begin
      rsp_ch.ready <= 1'b0;
      hold_cnt <= HOLD_LEN;
      hold_seen <= hold_asks;
    end else begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= STALL_PCT);
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= STUCK_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    inv_sp = 32'h0001_0000;
    npd    = 32'h0001_0000;
    tol    = '0;
    fill   = 0;
    bmin_i = 65535;
    bmin_j = 65535;
    bmax_i = -65536;
    bmax_j = -65536;
    calm = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_back_pressure();
    test_random_traffic();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
